// ===== rtl/core/prp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prp_pkg
// Shared types and codes of the plugin record parser: transaction structs,
// result kind codes, configuration register indexes and queue sizing.
// ----------------------------------------------------------------------------
package prp_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned CFG_INDEX_W = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_MIN_VERSION = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_VERSION = CFG_INDEX_W'(1);

	localparam logic [7:0] MIN_VERSION_RESET = 8'd1;
	localparam logic [7:0] MAX_VERSION_RESET = 8'd2;

	localparam logic [7:0] CR_CODE = 8'h0D;

	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_XBYTE   = 3'd1;
	localparam logic [2:0] KIND_XEND    = 3'd2;
	localparam logic [2:0] KIND_MBYTE   = 3'd3;
	localparam logic [2:0] KIND_MEND    = 3'd4;
	localparam logic [2:0] KIND_BADVER  = 3'd5;
	localparam logic [2:0] KIND_BAD     = 3'd6;
	localparam logic [2:0] KIND_DONE    = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  version;
		logic [15:0] flags;
		logic [31:0] main_uid;
		logic [31:0] sub_uid;
		logic [7:0]  entry_byte;
		logic [7:0]  entry_index;
		logic        record_end;
	} result_t;

endpackage : prp_pkg
`default_nettype wire

// ===== rtl/core/prp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prp_front
// Byte classifier: walks the record layout one byte per accepted transaction
// and produces at most one result for the queue.
// ----------------------------------------------------------------------------
module prp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire prp_pkg::item_t   item,
	input  wire logic [7:0]       min_version,
	input  wire logic [7:0]       max_version,
	output logic                  res_valid,
	output prp_pkg::result_t      res
);
	import prp_pkg::*;

	typedef enum logic [2:0] {
		PH_VER,
		PH_HDR,
		PH_XCNT,
		PH_XENT,
		PH_MCNT,
		PH_MENT,
		PH_SKIP
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  pos_q, pos_d;
	logic [7:0]  ver_q, ver_d;
	logic [15:0] flags_q, flags_d;
	logic [31:0] main_q, main_d;
	logic [31:0] sub_q, sub_d;
	logic [7:0]  left_q, left_d;
	logic [7:0]  cnt_q, cnt_d;
	logic        started_q, started_d;

	logic [7:0]  b;
	logic        last;
	logic        emit;
	logic [2:0]  kind;
	logic [7:0]  eb;
	logic [7:0]  idx;
	logic        mime;
	logic [7:0]  left_dec;

	assign b        = item.data_byte;
	assign last     = item.last_byte;
	assign left_dec = left_q - 8'd1;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		ver_d     = ver_q;
		flags_d   = flags_q;
		main_d    = main_q;
		sub_d     = sub_q;
		left_d    = left_q;
		cnt_d     = cnt_q;
		started_d = started_q;
		emit      = 1'b0;
		kind      = KIND_HEADER;
		eb        = 8'd0;
		idx       = 8'd0;
		mime      = (phase_q == PH_MCNT) || (phase_q == PH_MENT);
		unique case (phase_q)
			PH_VER: begin
				ver_d = b;
				if ((b < min_version) || (b > max_version)) begin
					emit    = 1'b1;
					kind    = KIND_BADVER;
					phase_d = PH_SKIP;
				end else if (last) begin
					emit = 1'b1;
					kind = KIND_BAD;
				end else begin
					phase_d = PH_HDR;
					pos_d   = 4'd1;
				end
			end
			PH_HDR: begin
				if (pos_q <= 4'd2) begin
					flags_d = {flags_q[7:0], b};
				end else if (pos_q <= 4'd6) begin
					main_d = {main_q[23:0], b};
				end else begin
					sub_d = {sub_q[23:0], b};
				end
				if (pos_q == 4'd10) begin
					emit    = 1'b1;
					kind    = KIND_HEADER;
					phase_d = PH_XCNT;
				end else if (last) begin
					emit = 1'b1;
					kind = (pos_q == 4'd6) ? KIND_HEADER : KIND_BAD;
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_XCNT, PH_MCNT: begin
				left_d    = b;
				cnt_d     = 8'd0;
				started_d = 1'b0;
				if (mime && (b == 8'd0)) begin
					emit    = 1'b1;
					kind    = KIND_DONE;
					phase_d = PH_SKIP;
				end else if (last) begin
					emit = 1'b1;
					kind = KIND_BAD;
				end else if (b == 8'd0) begin
					phase_d = PH_MCNT;
				end else begin
					phase_d = mime ? PH_MENT : PH_XENT;
				end
			end
			PH_XENT, PH_MENT: begin
				if (b == CR_CODE) begin
					if (!started_q) begin
						// empty entry: flag it and drop the rest of the record
						emit    = 1'b1;
						kind    = KIND_BAD;
						phase_d = PH_SKIP;
					end else begin
						started_d = 1'b0;
						left_d    = left_dec;
						cnt_d     = cnt_q + 8'd1;
						emit      = 1'b1;
						if (left_dec == 8'd0) begin
							if (mime) begin
								kind    = KIND_MEND;
								idx     = cnt_q;
								phase_d = PH_SKIP;
							end else if (last) begin
								kind = KIND_BAD;
							end else begin
								kind    = KIND_XEND;
								idx     = cnt_q;
								phase_d = PH_MCNT;
							end
						end else if (last) begin
							kind = KIND_BAD;
						end else begin
							kind = mime ? KIND_MEND : KIND_XEND;
							idx  = cnt_q;
						end
					end
				end else if (last) begin
					emit = 1'b1;
					kind = KIND_BAD;
				end else begin
					started_d = 1'b1;
					emit      = 1'b1;
					kind      = mime ? KIND_MBYTE : KIND_XBYTE;
					eb        = b;
					idx       = cnt_q;
				end
			end
			PH_SKIP: begin
			end
			default: begin
			end
		endcase
	end

	assign res_valid       = step && emit;
	assign res.kind        = kind;
	assign res.version     = ver_d;
	assign res.flags       = flags_d;
	assign res.main_uid    = main_d;
	assign res.sub_uid     = sub_d;
	assign res.entry_byte  = eb;
	assign res.entry_index = idx;
	assign res.record_end  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_VER;
			pos_q     <= 4'd0;
			ver_q     <= 8'd0;
			flags_q   <= 16'd0;
			main_q    <= 32'd0;
			sub_q     <= 32'd0;
			left_q    <= 8'd0;
			cnt_q     <= 8'd0;
			started_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				phase_q   <= PH_VER;
				pos_q     <= 4'd0;
				ver_q     <= 8'd0;
				flags_q   <= 16'd0;
				main_q    <= 32'd0;
				sub_q     <= 32'd0;
				left_q    <= 8'd0;
				cnt_q     <= 8'd0;
				started_q <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				pos_q     <= pos_d;
				ver_q     <= ver_d;
				flags_q   <= flags_d;
				main_q    <= main_d;
				sub_q     <= sub_d;
				left_q    <= left_d;
				cnt_q     <= cnt_d;
				started_q <= started_d;
			end
		end
	end

endmodule : prp_front
`default_nettype wire

// ===== rtl/core/prp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prp_queue
// Result queue between the classifier and the consumer; presents the oldest
// result and lets either side stall on its own.
// ----------------------------------------------------------------------------
module prp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire prp_pkg::result_t wr_data,
	input  wire logic             rd_en,
	output prp_pkg::result_t      rd_data,
	output logic                  full,
	output logic                  empty
);
	import prp_pkg::*;

	result_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]  wptr_q;
	logic [QUEUE_PTR_W-1:0]  rptr_q;
	logic [QUEUE_CNT_W-1:0]  count_q;
	logic                    do_wr;
	logic                    do_rd;

	assign full    = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + QUEUE_PTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + QUEUE_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule : prp_queue
`default_nettype wire

// ===== rtl/core/plugin_record_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plugin_record_parser
// Parses plugin descriptor records byte by byte into header, extension, MIME
// and status results.
// ----------------------------------------------------------------------------
// Result path: a result is written into the result queue when its byte is taken and
// shows on the result side once the results ahead of it are popped. Throughput: one
// byte per cycle, set by the combinational classifier step; the four-entry result
// queue only throttles input when the consumer stops popping. Reset: arst_n clears
// the parse state and the queue at once and restores the version range to 1..2.
// ----------------------------------------------------------------------------
module plugin_record_parser (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input side
	input  wire logic                            push,
	output logic                                 full,
	input  wire prp_pkg::item_t                  item,
	// result side
	output logic                                 empty,
	input  wire logic                            pop,
	output prp_pkg::result_t                     result,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [prp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [7:0]                      cfg_data
);
	import prp_pkg::*;

	logic [7:0] min_ver_q;
	logic [7:0] max_ver_q;
	logic       step;
	logic       res_valid;
	result_t    res;

	// Configuration writes are always taken; unknown indexes drop silently.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ver_q <= MIN_VERSION_RESET;
			max_ver_q <= MAX_VERSION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_VERSION: min_ver_q <= cfg_data;
				REG_MAX_VERSION: max_ver_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A byte is taken whenever the queue has room, even if it yields no result,
	// so the classifier keeps pace with the input at one transaction a cycle.
	assign step = push && !full;

	prp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item),
		.min_version (min_ver_q),
		.max_version (max_ver_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Hold finished results here until the consumer pops them.
	prp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.rd_en   (pop),
		.rd_data (result),
		.full    (full),
		.empty   (empty)
	);

endmodule : plugin_record_parser
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for plugin_record_parser. Byte streams made of directed
// records and random records (well-formed, cut short, broken and noise) are
// pushed at random pace under several version ranges. An in-bench parser
// predicts each result, and every popped result is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
	import prp_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned REPORT_LIMIT  = 10;

	// parse position within the current record
	typedef enum logic [2:0] {
		AT_VERSION,
		AT_HEADER,
		AT_EXT_COUNT,
		AT_EXT_ENTRY,
		AT_MIME_COUNT,
		AT_MIME_ENTRY,
		AT_SKIP
	} parse_phase_t;

	logic clk;
	logic arst_n = 1'b0;

	logic push = 1'b0;
	logic full;
	item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	// bytes waiting to be pushed, and results the parser must still produce
	item_t byte_stream[$];
	result_t predicted_results[$];
	logic [7:0] rec_bytes[$];

	int unsigned bytes_queued = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_gap = 0;
	int unsigned pop_gap = 0;
	bit idle_on = 1'b1;

	// mirror of the parser: version range and per-record state
	logic [7:0] min_ver;
	logic [7:0] max_ver;
	parse_phase_t phase_q;
	logic [3:0] hdr_pos;
	logic [7:0] ver_q;
	logic [15:0] flags_q;
	logic [31:0] main_uid_q;
	logic [31:0] sub_uid_q;
	logic [7:0] entries_left;
	logic [7:0] entry_count;
	logic entry_open;

	plugin_record_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ------------------------------------------------------------------------
	// Parser mirror
	// ------------------------------------------------------------------------

	task automatic clear_record();
		phase_q = AT_VERSION;
		hdr_pos = '0;
		ver_q = '0;
		flags_q = '0;
		main_uid_q = '0;
		sub_uid_q = '0;
		entries_left = '0;
		entry_count = '0;
		entry_open = 1'b0;
	endtask

	// Queue one expected result; header fields always carry what is captured so far.
	task automatic queue_result(input logic [2:0] kind, input logic [7:0] ch,
			input logic [7:0] idx, input logic at_end);
		result_t r;
		r.kind = kind;
		r.version = ver_q;
		r.flags = flags_q;
		r.main_uid = main_uid_q;
		r.sub_uid = sub_uid_q;
		r.entry_byte = ch;
		r.entry_index = idx;
		r.record_end = at_end;
		predicted_results.push_back(r);
	endtask

	// Advance the mirror by one accepted byte.
	task automatic parse_byte(input item_t it);
		logic [7:0] b;
		logic last;
		logic is_mime;
		logic [7:0] idx;
		b = it.data_byte;
		last = it.last_byte;
		case (phase_q)
			AT_VERSION: begin
				ver_q = b;
				if (b < min_ver || b > max_ver) begin
					queue_result(KIND_BADVER, 8'h00, 8'h00, last);
					phase_q = AT_SKIP;
				end else if (last) begin
					queue_result(KIND_BAD, 8'h00, 8'h00, 1'b1);
				end else begin
					phase_q = AT_HEADER;
					hdr_pos = 4'd1;
				end
			end
			AT_HEADER: begin
				if (hdr_pos <= 4'd2)
					flags_q = {flags_q[7:0], b};
				else if (hdr_pos <= 4'd6)
					main_uid_q = {main_uid_q[23:0], b};
				else
					sub_uid_q = {sub_uid_q[23:0], b};
				if (hdr_pos == 4'd10) begin
					queue_result(KIND_HEADER, 8'h00, 8'h00, last);
					phase_q = AT_EXT_COUNT;
				end else if (last) begin
					// a record may stop right after the main UID
					queue_result((hdr_pos == 4'd6) ? KIND_HEADER : KIND_BAD, 8'h00, 8'h00, 1'b1);
				end else begin
					hdr_pos = hdr_pos + 4'd1;
				end
			end
			AT_EXT_COUNT, AT_MIME_COUNT: begin
				is_mime = (phase_q == AT_MIME_COUNT);
				entries_left = b;
				entry_count = '0;
				entry_open = 1'b0;
				if (is_mime && b == 8'h00) begin
					queue_result(KIND_DONE, 8'h00, 8'h00, last);
					phase_q = AT_SKIP;
				end else if (last) begin
					queue_result(KIND_BAD, 8'h00, 8'h00, 1'b1);
				end else if (b == 8'h00) begin
					phase_q = AT_MIME_COUNT;
				end else begin
					phase_q = is_mime ? AT_MIME_ENTRY : AT_EXT_ENTRY;
				end
			end
			AT_EXT_ENTRY, AT_MIME_ENTRY: begin
				is_mime = (phase_q == AT_MIME_ENTRY);
				idx = entry_count;
				if (b == CR_CODE) begin
					if (!entry_open) begin
						// empty entry: drop the rest of the record
						queue_result(KIND_BAD, 8'h00, 8'h00, last);
						phase_q = AT_SKIP;
					end else begin
						entry_open = 1'b0;
						entries_left = entries_left - 8'd1;
						entry_count = entry_count + 8'd1;
						if (entries_left == 8'h00) begin
							if (is_mime) begin
								queue_result(KIND_MEND, 8'h00, idx, last);
								phase_q = AT_SKIP;
							end else if (last) begin
								queue_result(KIND_BAD, 8'h00, 8'h00, 1'b1);
							end else begin
								queue_result(KIND_XEND, 8'h00, idx, 1'b0);
								phase_q = AT_MIME_COUNT;
							end
						end else if (last) begin
							queue_result(KIND_BAD, 8'h00, 8'h00, 1'b1);
						end else begin
							queue_result(is_mime ? KIND_MEND : KIND_XEND, 8'h00, idx, 1'b0);
						end
					end
				end else if (last) begin
					queue_result(KIND_BAD, 8'h00, 8'h00, 1'b1);
				end else begin
					entry_open = 1'b1;
					queue_result(is_mime ? KIND_MBYTE : KIND_XBYTE, b, idx, 1'b0);
				end
			end
			default: begin
			end
		endcase
		if (last)
			clear_record();
	endtask

	// ------------------------------------------------------------------------
	// Driver and monitor
	// ------------------------------------------------------------------------

	// Push side: hold the head byte until taken, with random bursts of idle cycles.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (send_gap > 0) begin
			send_gap--;
			push <= 1'b0;
		end else if (idle_on && $urandom_range(0, 19) == 0) begin
			send_gap = $urandom_range(0, 10);
			push <= 1'b0;
		end else if (byte_stream.size() != 0) begin
			push <= 1'b1;
			item <= byte_stream[0];
		end else begin
			push <= 1'b0;
		end
	end

	// Pop side: stall in random bursts as well.
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_gap > 0) begin
			pop_gap--;
			pop <= 1'b0;
		end else if (idle_on && $urandom_range(0, 15) == 0) begin
			pop_gap = $urandom_range(0, 10);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what, input result_t want, input result_t got);
		if (mismatch_count < REPORT_LIMIT) begin
			$write("%0t %s: exp/act kind %0d/%0d ver %h/%h flags %h/%h main %h/%h ",
				$realtime, what, want.kind, got.kind, want.version, got.version,
				want.flags, got.flags, want.main_uid, got.main_uid);
			$display("sub %h/%h byte %h/%h idx %0d/%0d end %b/%b",
				want.sub_uid, got.sub_uid, want.entry_byte, got.entry_byte,
				want.entry_index, got.entry_index, want.record_end, got.record_end);
		end
		mismatch_count++;
	endtask

	// Sample every transaction at the rising edge.
	always @(posedge clk) begin : monitor
		result_t want;
		if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MIN_VERSION)
				min_ver = cfg_data;
			else if (cfg_index == REG_MAX_VERSION)
				max_ver = cfg_data;
		end
		if (push && !full) begin
			parse_byte(item);
			byte_stream.delete(0);
		end
		if (pop && !empty) begin
			if (predicted_results.size() == 0) begin
				report_mismatch("unexpected result", '0, result);
			end else begin
				want = predicted_results.pop_front();
				if (result.kind !== want.kind || result.version !== want.version ||
						result.flags !== want.flags || result.main_uid !== want.main_uid ||
						result.sub_uid !== want.sub_uid || result.entry_byte !== want.entry_byte ||
						result.entry_index !== want.entry_index ||
						result.record_end !== want.record_end)
					report_mismatch("result mismatch", want, result);
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Any byte but the entry terminator.
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b == CR_CODE);
		return b;
	endfunction

	// Move the built record to the push queue, marking its final byte.
	task automatic send_record();
		item_t it;
		foreach (rec_bytes[i]) begin
			it.data_byte = rec_bytes[i];
			it.last_byte = (i == rec_bytes.size() - 1);
			byte_stream.push_back(it);
			bytes_queued++;
		end
		rec_bytes.delete();
	endtask

	// Count byte and entries of one list; now and then a count far past the usual.
	task automatic add_list();
		int unsigned n;
		int unsigned len;
		n = ($urandom_range(0, 31) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
		rec_bytes.push_back(8'(n));
		repeat (n) begin
			len = (n > 4) ? 1 : $urandom_range(1, 4);
			if ($urandom_range(0, 15) == 0)
				len = 0;
			repeat (len)
				rec_bytes.push_back(text_byte());
			rec_bytes.push_back(CR_CODE);
		end
	endtask

	// Build and queue one random record for the version range lo..hi.
	task automatic gen_record(input logic [7:0] lo, input logic [7:0] hi);
		int unsigned shape;
		int unsigned keep;
		shape = $urandom_range(0, 19);
		if (shape < 2) begin
			// noise with terminators sprinkled in
			repeat ($urandom_range(1, 14))
				rec_bytes.push_back(($urandom_range(0, 5) == 0) ? CR_CODE : 8'($urandom));
		end else begin
			if (lo <= hi && $urandom_range(0, 7) != 0)
				rec_bytes.push_back(8'($urandom_range(hi, lo)));
			else
				rec_bytes.push_back(8'($urandom));
			repeat (6)
				rec_bytes.push_back(8'($urandom));
			// shape 2 stops after the main UID, shape 3 after the sub UID
			if (shape != 2) begin
				repeat (4)
					rec_bytes.push_back(8'($urandom));
				if (shape != 3) begin
					add_list();
					add_list();
					if ($urandom_range(0, 3) == 0)
						repeat ($urandom_range(1, 3))
							rec_bytes.push_back(8'($urandom));
				end
			end
			if ($urandom_range(0, 4) == 0) begin
				keep = $urandom_range(1, rec_bytes.size());
				while (rec_bytes.size() > keep)
					void'(rec_bytes.pop_back());
			end
		end
		send_record();
	endtask

	// Hold until every byte is taken and every result popped, then let the pipe drain.
	task automatic wait_idle();
		while (byte_stream.size() != 0 || predicted_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] lo, input logic [7:0] hi, input int unsigned n);
		int unsigned start;
		write_reg(REG_MIN_VERSION, lo);
		write_reg(REG_MAX_VERSION, hi);
		start = bytes_queued;
		while (bytes_queued - start < n)
			gen_record(lo, hi);
		wait_idle();
	endtask

	initial begin
		min_ver = MIN_VERSION_RESET;
		max_ver = MAX_VERSION_RESET;
		clear_record();
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// version below the reset range
		rec_bytes = '{8'h00};
		send_record();
		// record cut off at its version byte
		rec_bytes = '{8'h01};
		send_record();
		// header ending at the main UID, version at the top of the range
		rec_bytes = '{8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_record();
		// one extension, no MIME types, then a trailing byte
		rec_bytes = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h01, 8'hFF, CR_CODE, 8'h00, 8'h55};
		send_record();
		wait_idle();

		run_phase(MIN_VERSION_RESET, MAX_VERSION_RESET, 150);

		// widest range plus one long record to walk the entry index up high
		write_reg(REG_MIN_VERSION, 8'h00);
		write_reg(REG_MAX_VERSION, 8'hFF);
		rec_bytes.push_back(8'h80);
		repeat (10)
			rec_bytes.push_back(8'($urandom));
		rec_bytes.push_back(8'd200);
		repeat (200) begin
			rec_bytes.push_back(text_byte());
			rec_bytes.push_back(CR_CODE);
		end
		rec_bytes.push_back(8'd130);
		repeat (130) begin
			rec_bytes.push_back(text_byte());
			rec_bytes.push_back(CR_CODE);
		end
		send_record();
		wait_idle();
		run_phase(8'h00, 8'hFF, 200);

		run_phase(8'h05, 8'h05, 100);
		// inverted range rejects every version
		run_phase(8'hC8, 8'h64, 60);
		run_phase(8'hFF, 8'hFF, 60);

		// full speed on both sides to close the run
		idle_on = 1'b0;
		run_phase(8'h00, 8'h03, 200);

		repeat (20)
			@(posedge clk);
		if (mismatch_count == 0 && predicted_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/prp_pkg.sv
rtl/core/prp_front.sv
rtl/core/prp_queue.sv
rtl/core/plugin_record_parser.sv
dv/testbench.sv
